@@ hw/rtl/sfla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants for the slab free-list allocator
// Field widths, status and opcode names, config register indexes.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int POOL_SLOTS_DEF = 1024;

    localparam int SLOT_IDX_W   = 10;
    localparam int HELD_W       = 26;
    localparam int RESV_W       = 11;
    localparam int STATUS_W     = 2;
    localparam int SLOT_BYTES_W = 16;
    localparam int FIRST_W      = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHUNK = 2'd1;

    typedef struct packed {
        logic                  op;
        logic [SLOT_IDX_W-1:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] granted_slot;
        logic [HELD_W-1:0]     allocated_bytes;
        logic [RESV_W-1:0]     reserved_slots;
    } rsp_t;

    typedef struct packed {
        logic [SLOT_BYTES_W-1:0] slot_bytes;
        logic [FIRST_W-1:0]      first_chunk_slots;
    } cfg_t;

endpackage : sfla_pkg
`default_nettype wire

@@ hw/rtl/slab_free_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slab_free_list_allocator: fixed-size slot allocator with LIFO free list
// Pops freed slots first, then hands out fresh slots of doubling chunks.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------
//  req      in         req_valid/req_stall  req_t  {op, slot_index}
//  rsp      out        rsp_valid/rsp_stall  rsp_t  {status, granted_slot,
//                                                   allocated_bytes,
//                                                   reserved_slots}
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  On accept, the link-store read at the list head is issued and busy_reg
//  is set; with busy_reg high the request executes and loads rsp_reg.
//  The registered read of the link store is why execution waits for busy_reg.
//  The response is flagged by rsp_valid_reg, which is set from busy_reg.
//  A response held by rsp_stall stalls the next request only; cfg is always
//  ready. Reset clears all pointers and counters; the link store needs none.
// ----------------------------------------------------------------------------
module slab_free_list_allocator
    import sfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output      logic                  req_stall,
    input  wire req_t                  req,
    output      logic                  rsp_valid,
    input  wire logic                  rsp_stall,
    output      rsp_t                  rsp,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic busy_reg;         // request registered, not yet executed
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    req_t item_reg;
    cfg_t cfg_reg;
    rsp_t result;
    logic req_xfer;

    assign cfg_ready = 1'b1;

    // one request in flight; the response slot must be free or draining
    assign req_stall = busy_reg || (rsp_valid_reg && rsp_stall);
    assign req_xfer  = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_bytes        <= SLOT_BYTES_W'(16);
            cfg_reg.first_chunk_slots <= FIRST_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SLOT_BYTES:  cfg_reg.slot_bytes        <= cfg_data;
                CFG_FIRST_CHUNK: cfg_reg.first_chunk_slots <= cfg_data[FIRST_W-1:0];
                default:         ;  // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= req_xfer;
            if (busy_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            item_reg <= req;
        end
        if (busy_reg)
        begin
            rsp_reg <= result;
        end
    end

    sfla_core #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_read (req_xfer),
        .exec       (busy_reg),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .result     (result)
    );

endmodule : slab_free_list_allocator
`default_nettype wire

@@ hw/rtl/sfla_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : sfla_ram
`default_nettype wire

@@ hw/rtl/sfla_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_core: allocator state and request execution
// Free-list head, fresh/chunk pointers, byte count and the link store.
// ----------------------------------------------------------------------------
module sfla_core
    import sfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start_read,   // request accepted: fetch link of head
    input  wire logic exec,         // execute the registered request
    input  wire req_t item,
    input  wire cfg_t cfg,
    output      rsp_t result
);

    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam int SZP_W  = $clog2(POOL_SLOTS + 2);
    localparam int SZ_W   = (FIRST_W > SZP_W) ? FIRST_W : SZP_W;
    localparam int SUM_W  = SZ_W + 1;
    localparam int HSUM_W = HELD_W + 1;
    localparam int LINK_W = IDX_W + 1;

    logic [IDX_W-1:0]  head_reg,      head_next;
    logic              empty_reg,     empty_next;
    logic [CNT_W-1:0]  fresh_reg,     fresh_next;
    logic [CNT_W-1:0]  chunk_end_reg, chunk_end_next;
    logic [SZ_W-1:0]   ncs_reg,       ncs_next;
    logic [HELD_W-1:0] held_reg,      held_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;

    logic [SZ_W-1:0]   size;
    logic              fits;
    logic [SUM_W-1:0]  dbl;
    logic [SZ_W-1:0]   ncs_open;
    logic [HSUM_W-1:0] held_sum;
    logic [HELD_W-1:0] held_add;
    logic [IDX_W-1:0]  granted;
    logic [STATUS_W-1:0] status;

    // link word: {last mark, next index}
    sfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (start_read),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        size     = (ncs_reg == '0) ? SZ_W'(cfg.first_chunk_slots) : ncs_reg;
        fits     = (size != '0) &&
                   ((SUM_W'(size) + SUM_W'(chunk_end_reg)) <= SUM_W'(POOL_SLOTS));
        dbl      = {size, 1'b0};
        // a doubled size past the pool never fits again
        ncs_open = (dbl > SUM_W'(POOL_SLOTS)) ? SZ_W'(POOL_SLOTS + 1) : SZ_W'(dbl);
        held_sum = HSUM_W'(held_reg) + HSUM_W'(cfg.slot_bytes);
        held_add = (held_sum > HSUM_W'(HELD_MAX)) ? HELD_MAX : HELD_W'(held_sum);

        head_next      = head_reg;
        empty_next     = empty_reg;
        fresh_next     = fresh_reg;
        chunk_end_next = chunk_end_reg;
        ncs_next       = ncs_reg;
        held_next      = held_reg;
        granted        = '0;
        status         = ST_OK;
        ram_we         = 1'b0;
        ram_waddr      = IDX_W'(item.slot_index);
        ram_wdata      = {empty_reg, head_reg};

        if (item.op == OP_ALLOC)
        begin
            if (!empty_reg)
            begin
                granted   = head_reg;
                held_next = held_add;
                if (ram_rdata[LINK_W-1])
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                end
                else
                begin
                    head_next = ram_rdata[IDX_W-1:0];
                end
            end
            else if (fresh_reg < chunk_end_reg)
            begin
                granted    = IDX_W'(fresh_reg);
                fresh_next = fresh_reg + 1'b1;
                held_next  = held_add;
            end
            else if (fits)
            begin
                chunk_end_next = CNT_W'(SUM_W'(chunk_end_reg) + SUM_W'(size));
                ncs_next       = ncs_open;
                granted        = IDX_W'(fresh_reg);
                fresh_next     = fresh_reg + 1'b1;
                held_next      = held_add;
            end
            else
            begin
                status = ST_EXHAUSTED;
            end
        end
        else
        begin
            if ((32'(item.slot_index) >= 32'(POOL_SLOTS)) ||
                (held_reg < HELD_W'(cfg.slot_bytes)))
            begin
                status = ST_UNDERFLOW;
            end
            else
            begin
                ram_we     = exec;
                head_next  = IDX_W'(item.slot_index);
                empty_next = 1'b0;
                held_next  = held_reg - HELD_W'(cfg.slot_bytes);
            end
        end

        result.status          = status;
        result.granted_slot    = SLOT_IDX_W'(granted);
        result.allocated_bytes = held_next;
        result.reserved_slots  = RESV_W'(chunk_end_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            empty_reg     <= 1'b1;
            fresh_reg     <= '0;
            chunk_end_reg <= '0;
            ncs_reg       <= '0;
            held_reg      <= '0;
        end
        else if (exec)
        begin
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            fresh_reg     <= fresh_next;
            chunk_end_reg <= chunk_end_next;
            ncs_reg       <= ncs_next;
            held_reg      <= held_next;
        end
    end

endmodule : sfla_core
`default_nettype wire
